// ===== sv/mep_pkg.sv =====
`timescale 1ns / 1ps

package mep_pkg;

  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_CC       = 2'd2;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CC       = 4'hB;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } entry_t;

  typedef struct packed {
    logic        msg_valid;
    logic [1:0]  msg_kind;
    logic [6:0]  note_number;
    logic [23:0] frequency;
    logic [15:0] velocity;
    logic [10:0] channel_index;
    logic [15:0] controller_value;
  } msg_t;

  // top octave pitches, Q16 Hz
  function automatic logic [29:0] octave_top(input logic [3:0] k);
    logic [29:0] r;
    begin
      case (k)
        4'd0:    r = 30'd548668578;
        4'd1:    r = 30'd581294106;
        4'd2:    r = 30'd615859656;
        4'd3:    r = 30'd652480572;
        4'd4:    r = 30'd691279090;
        4'd5:    r = 30'd732384684;
        4'd6:    r = 30'd775934544;
        4'd7:    r = 30'd822074013;
        4'd8:    r = 30'd870957082;
        4'd9:    r = 30'd922746880;
        4'd10:   r = 30'd977616234;
        4'd11:   r = 30'd1035748352;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

  // (v * 32768 + 63) / 127 = 258 v + (2 v + 63) / 127
  function automatic logic [15:0] to_q15(input logic [6:0] v);
    logic [8:0]  t;
    logic [15:0] base;
    logic [1:0]  corr;
    begin
      t    = {1'b0, v, 1'b0} + 9'd63;
      base = {1'b0, v, 8'b0} + {8'b0, v, 1'b0};
      if (t >= 9'd254) begin
        corr = 2'd2;
      end else if (t >= 9'd127) begin
        corr = 2'd1;
      end else begin
        corr = 2'd0;
      end
      return base + {14'b0, corr};
    end
  endfunction

  function automatic logic [23:0] note_freq(input logic [6:0] n);
    logic [12:0] prod;
    logic [3:0]  oct;
    logic [6:0]  rem;
    logic [4:0]  sh;
    logic [30:0] sum;
    logic [30:0] val;
    begin
      prod = {6'b0, n} * 13'd43;
      oct  = prod[12:9];
      rem  = n - ({3'b0, oct} * 7'd12);
      sh   = 5'd16 - {1'b0, oct};
      sum  = {1'b0, octave_top(rem[3:0])} + (31'd1 << (sh - 5'd1));
      val  = sum >> sh;
      return val[23:0];
    end
  endfunction

endpackage

// ===== sv/midi_event_parser_fifo.sv =====
`timescale 1ns / 1ps

// usb midi event parser with a message queue
// input: start/busy command channel; command 0 pushes one 4-byte event
// packet (header_byte, status_byte, data_one, data_two), command 1 pops the
// oldest queued message. a word is taken at a clock edge with start high
// and busy low.
// output: every command gives exactly one result word, shown for one cycle
// while done is high; the receiver cannot stall and must take it then.
// a push result appears in the cycle after acceptance and a new
// command can be taken in that same cycle, so pushes run one per cycle.
// a pop reads the message store (synchronous read), raising busy
// for one cycle; its result is registered from the store's read register,
// and no new command is taken until it appears.
// reset (rst, synchronous) empties the queue and clears done and busy;
// the store itself is not cleared, entries are read only after a write.
// valid pushes into a full queue are discarded and flagged by packet_dropped;
// a pop of an empty queue returns msg_valid low.

module midi_event_parser_fifo import mep_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  header_byte,
  input  logic [7:0]  status_byte,
  input  logic [7:0]  data_one,
  input  logic [7:0]  data_two,
  output logic        done,
  output logic        msg_valid,
  output logic [1:0]  msg_kind,
  output logic [6:0]  note_number,
  output logic [23:0] frequency,
  output logic [15:0] velocity,
  output logic [10:0] channel_index,
  output logic [15:0] controller_value,
  output logic        fifo_empty,
  output logic        packet_dropped
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  logic [AW-1:0] wr_idx;
  logic          wr_wrap;
  logic [AW-1:0] rd_idx;
  logic          rd_wrap;
  logic          rd_pending;
  logic          pop_hit;
  logic          pop_empty;

  logic          accept;
  logic          empty;
  logic          full;
  logic          type_ok;
  logic          push_ok;
  logic          pop_go;
  logic [AW-1:0] wr_idx_next;
  logic          wr_wrap_next;
  logic [AW-1:0] rd_idx_next;
  logic          rd_wrap_next;
  logic          empty_after_pop;
  entry_t        wentry;
  entry_t        rentry;
  msg_t          msg;

  assign busy    = rd_pending;
  assign accept  = start && !busy;
  assign empty   = (wr_idx == rd_idx) && (wr_wrap == rd_wrap);
  assign full    = (wr_idx == rd_idx) && (wr_wrap != rd_wrap);
  assign type_ok = (header_byte != 8'h00) &&
                   (status_byte[7:4] inside {TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_CC});
  assign push_ok = accept && !command && type_ok && !full;
  assign pop_go  = accept && command && !empty;

  always_comb begin
    wr_idx_next  = (wr_idx == LAST) ? '0 : wr_idx + 1'b1;
    wr_wrap_next = (wr_idx == LAST) ? !wr_wrap : wr_wrap;
    rd_idx_next  = (rd_idx == LAST) ? '0 : rd_idx + 1'b1;
    rd_wrap_next = (rd_idx == LAST) ? !rd_wrap : rd_wrap;
    empty_after_pop = (rd_idx_next == wr_idx) && (rd_wrap_next == wr_wrap);
  end

  always_comb begin
    wentry.kind     = (status_byte[7:4] == TYPE_CC) ? KIND_CC :
                      (status_byte[7:4] == TYPE_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
    wentry.channel  = status_byte[3:0];
    wentry.data_one = data_one[6:0];
    wentry.data_two = data_two[6:0];
  end

  mep_store #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_idx),
    .wdata (wentry),
    .re    (pop_go),
    .raddr (rd_idx),
    .rdata (rentry)
  );

  mep_expand u_expand (
    .hit (pop_hit),
    .e   (rentry),
    .msg (msg)
  );

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx  <= '0;
      wr_wrap <= 1'b0;
      rd_idx  <= '0;
      rd_wrap <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_idx  <= wr_idx_next;
        wr_wrap <= wr_wrap_next;
      end
      if (pop_go) begin
        rd_idx  <= rd_idx_next;
        rd_wrap <= rd_wrap_next;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      done       <= 1'b0;
    end else begin
      rd_pending <= accept && command;
      done       <= (accept && !command) || rd_pending;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept && command) begin
      pop_hit   <= !empty;
      pop_empty <= empty || empty_after_pop;
    end
    if (rd_pending) begin
      msg_valid        <= msg.msg_valid;
      msg_kind         <= msg.msg_kind;
      note_number      <= msg.note_number;
      frequency        <= msg.frequency;
      velocity         <= msg.velocity;
      channel_index    <= msg.channel_index;
      controller_value <= msg.controller_value;
      fifo_empty       <= pop_empty;
      packet_dropped   <= 1'b0;
    end else if (accept && !command) begin
      msg_valid        <= 1'b0;
      msg_kind         <= '0;
      note_number      <= '0;
      frequency        <= '0;
      velocity         <= '0;
      channel_index    <= '0;
      controller_value <= '0;
      fifo_empty       <= empty && !push_ok;
      packet_dropped   <= type_ok && full;
    end
  end

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command) |=> (busy && !done))
    else $error("pop did not raise busy");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done && !packet_dropped))
    else $error("pop result missing after read");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !command) |=> (done && !msg_valid))
    else $error("push result missing");

  a_ptr_sane: assert property (@(posedge clk) disable iff (rst)
    (wr_idx <= LAST) && (rd_idx <= LAST))
    else $error("queue pointer out of range");

  a_cc_fields: assert property (@(posedge clk) disable iff (rst)
    (done && msg_valid && (msg_kind == KIND_CC)) |-> ((note_number == '0) && (velocity == '0)))
    else $error("control change carries note fields");

endmodule

// ===== sv/mep_store.sv =====
`timescale 1ns / 1ps

module mep_store import mep_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mep_expand.sv =====
`timescale 1ns / 1ps

module mep_expand import mep_pkg::*; (
  input  logic   hit,
  input  entry_t e,
  output msg_t   msg
);

  always_comb begin
    msg = '0;
    if (hit) begin
      msg.msg_valid = 1'b1;
      msg.msg_kind  = e.kind;
      if (e.kind == KIND_CC) begin
        msg.channel_index    = {e.data_one, e.channel};
        msg.controller_value = to_q15(e.data_two);
      end else begin
        msg.note_number   = e.data_one;
        msg.frequency     = note_freq(e.data_one);
        msg.velocity      = to_q15(e.data_two);
        msg.channel_index = {7'b0, e.channel};
      end
    end
  end

endmodule
